FILE: rtl/core/hsv_pkg.sv
package hsv_pkg;

    typedef logic [15:0] t_rem;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] value;
    } t_hsv;

    typedef struct packed {
        t_rem       hue_rem;
        logic [7:0] hue_den;
        logic [7:0] hue_quo;
        t_rem       sat_rem;
        logic [7:0] sat_den;
        logic [7:0] sat_quo;
        logic [7:0] value;
    } t_div_lane;

    localparam int unsigned QUO_BITS    = 8;
    localparam int unsigned HUE_STEP    = 30;
    localparam int unsigned HUE_GREEN   = 60;
    localparam int unsigned HUE_BLUE    = 120;
    localparam int unsigned HUE_RED_NEG = 180;
    localparam int unsigned SAT_SCALE   = 255;

endpackage

FILE: rtl/core/hsv_prep.sv
module hsv_prep (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  hsv_pkg::t_rgb          i_pixel,
    output logic                   o_valid,
    output hsv_pkg::t_div_lane     o_lane
);

    logic                 r_valid;
    hsv_pkg::t_div_lane   r_lane;
    hsv_pkg::t_div_lane   n_lane;

    logic [7:0]  max_ch;
    logic [7:0]  min_ch;
    logic [7:0]  delta;
    logic [7:0]  pos_ch;
    logic [7:0]  neg_ch;
    logic [16:0] base;
    logic [16:0] hue_num;

    always_comb begin
        max_ch = i_pixel.red;
        min_ch = i_pixel.red;
        if (i_pixel.green > max_ch) max_ch = i_pixel.green;
        if (i_pixel.blue > max_ch) max_ch = i_pixel.blue;
        if (i_pixel.green < min_ch) min_ch = i_pixel.green;
        if (i_pixel.blue < min_ch) min_ch = i_pixel.blue;
        delta = max_ch - min_ch;
    end

    // Each branch is folded into base + 30*pos - 30*neg, which never goes negative.
    always_comb begin
        priority if (max_ch == i_pixel.red) begin
            pos_ch = i_pixel.green;
            neg_ch = i_pixel.blue;
            base   = (i_pixel.green >= i_pixel.blue) ? 17'd0 :
                     17'(delta) * 17'(hsv_pkg::HUE_RED_NEG);
        end else if (max_ch == i_pixel.green) begin
            pos_ch = i_pixel.blue;
            neg_ch = i_pixel.red;
            base   = 17'(delta) * 17'(hsv_pkg::HUE_GREEN);
        end else begin
            pos_ch = i_pixel.red;
            neg_ch = i_pixel.green;
            base   = 17'(delta) * 17'(hsv_pkg::HUE_BLUE);
        end
        hue_num = base + 17'(pos_ch) * 17'(hsv_pkg::HUE_STEP)
                       - 17'(neg_ch) * 17'(hsv_pkg::HUE_STEP);
    end

    // A grey or black pixel divides zero by one, so both quotients come out zero.
    always_comb begin
        n_lane.value   = max_ch;
        n_lane.hue_quo = '0;
        n_lane.sat_quo = '0;
        if (delta == 8'd0) begin
            n_lane.hue_rem = '0;
            n_lane.hue_den = 8'd1;
            n_lane.sat_rem = '0;
            n_lane.sat_den = 8'd1;
        end else begin
            n_lane.hue_rem = hue_num[15:0];
            n_lane.hue_den = delta;
            n_lane.sat_rem = 16'(delta) * 16'(hsv_pkg::SAT_SCALE);
            n_lane.sat_den = max_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

FILE: rtl/core/hsv_div_cell.sv
module hsv_div_cell #(
    parameter int unsigned BIT_POS = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  hsv_pkg::t_div_lane     i_lane,
    output logic                   o_valid,
    output hsv_pkg::t_div_lane     o_lane
);

    logic                 r_valid;
    hsv_pkg::t_div_lane   r_lane;
    hsv_pkg::t_div_lane   n_lane;
    hsv_pkg::t_rem        hue_trial;
    hsv_pkg::t_rem        sat_trial;

    always_comb begin
        n_lane    = i_lane;
        hue_trial = hsv_pkg::t_rem'(i_lane.hue_den) << BIT_POS;
        sat_trial = hsv_pkg::t_rem'(i_lane.sat_den) << BIT_POS;
        if (i_lane.hue_rem >= hue_trial) begin
            n_lane.hue_rem          = i_lane.hue_rem - hue_trial;
            n_lane.hue_quo[BIT_POS] = 1'b1;
        end
        if (i_lane.sat_rem >= sat_trial) begin
            n_lane.sat_rem          = i_lane.sat_rem - sat_trial;
            n_lane.sat_quo[BIT_POS] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

FILE: rtl/core/rgb_to_hsv_pixel_core.sv
// Converts one 8-bit RGB pixel to 8-bit HSV (hue in half degrees, 0 to 179) and accepts a
// new pixel on every clock; busy is always low. Each result appears on o_result with o_valid
// high for one cycle, after the prep register finds the largest and smallest channel and
// forms both numerators, and a row of eight division cells resolves one bit of hue and
// of saturation per cycle. The receiver must take every result as it appears, since nothing
// is held back.
module rgb_to_hsv_pixel_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  hsv_pkg::t_rgb    i_pixel,
    output logic             o_valid,
    output hsv_pkg::t_hsv    o_result
);

    localparam int unsigned NUM_CELLS = hsv_pkg::QUO_BITS;
    localparam int unsigned LATENCY   = NUM_CELLS + 1;

    logic                 accept;
    logic                 lane_valid [0:NUM_CELLS];
    hsv_pkg::t_div_lane   lane       [0:NUM_CELLS];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    hsv_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pixel  (i_pixel),
        .o_valid  (lane_valid[0]),
        .o_lane   (lane[0])
    );

    for (genvar gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
        hsv_div_cell #(
            .BIT_POS (NUM_CELLS - 1 - gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (lane_valid[gi]),
            .i_lane  (lane[gi]),
            .o_valid (lane_valid[gi + 1]),
            .o_lane  (lane[gi + 1])
        );
    end

    assign o_valid             = lane_valid[NUM_CELLS];
    assign o_result.hue        = lane[NUM_CELLS].hue_quo;
    assign o_result.saturation = lane[NUM_CELLS].sat_quo;
    assign o_result.value      = lane[NUM_CELLS].value;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("pixel transfer did not produce a result on time");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.hue <= 8'd179))
        else $error("hue out of range");

    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.saturation == 8'd0)) |-> (o_result.hue == 8'd0))
        else $error("grey pixel with nonzero hue");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");
`endif

endmodule
